// File: design/pgsc_pkg.sv
// pgsc_pkg: shared types and constants for the paddle gear shift controller.
// Used by pgsc_step and paddle_gear_shift_controller; no dependencies.
package pgsc_pkg;

  localparam int unsigned GearW  = 3;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned PulseW = 7;
  localparam int unsigned DivW   = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_NEUTRAL_HOLD = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_POLL_INTERVAL = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_START_GEAR = 2'd2;

  localparam logic [HoldW-1:0]  NEUTRAL_HOLD_RST  = 16'd1000;
  localparam logic [DivW-1:0]   POLL_INTERVAL_RST = 8'd10;
  localparam logic [GearW-1:0]  START_GEAR_RST    = 3'd1;
  localparam logic [PulseW-1:0] NEUTRAL_PULSE     = 7'd50;
  localparam logic [PulseW-1:0] PULSE_BASE        = 7'd45;
  localparam logic [PulseW-1:0] PULSE_STEP        = 7'd5;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_UP      = 2'd1,
    KIND_DOWN    = 2'd2,
    KIND_NEUTRAL = 2'd3
  } pulse_kind_t;

  typedef struct packed {
    logic [GearW-1:0]  gear;
    logic              lock;
    logic [HoldW-1:0]  hold;
    logic [PulseW-1:0] left;
    pulse_kind_t       kind;
    logic [DivW-1:0]   div;
  } ctl_state_t;

  typedef struct packed {
    logic             up_solenoid;
    logic             down_solenoid;
    logic [GearW-1:0] gear;
    logic             shift_event;
    logic             shift_was_up;
  } result_t;

endpackage

// File: design/pgsc_step.sv
// pgsc_step: next-state and result logic for one 1 ms tick.
// Depends on pgsc_pkg.
module pgsc_step #(
  parameter int unsigned TOP_GEAR = 6
) (
  input  pgsc_pkg::ctl_state_t              cur,
  input  logic                              up_button,
  input  logic                              down_button,
  input  logic [pgsc_pkg::HoldW-1:0]        neutral_hold_ms,
  input  logic [pgsc_pkg::DivW-1:0]         poll_interval,
  output pgsc_pkg::ctl_state_t              nxt,
  output pgsc_pkg::result_t                 res
);

  localparam logic [pgsc_pkg::GearW-1:0] TopGearL = pgsc_pkg::GearW'(TOP_GEAR);
  localparam logic [pgsc_pkg::GearW-1:0] LowGear  = 3'd1;

  logic [pgsc_pkg::DivW-1:0]   interval;
  logic [pgsc_pkg::DivW-1:0]   div_inc;
  logic [pgsc_pkg::PulseW-1:0] left_dec;
  logic [pgsc_pkg::PulseW-1:0] shift_len;
  logic [pgsc_pkg::HoldW:0]    hold_sum;
  logic [pgsc_pkg::HoldW-1:0]  hold_sat;
  logic                        started;

  always_comb begin
    interval  = (poll_interval == '0) ? pgsc_pkg::DivW'(1) : poll_interval;
    div_inc   = cur.div + pgsc_pkg::DivW'(1);
    left_dec  = (cur.left != '0) ? cur.left - pgsc_pkg::PulseW'(1) : cur.left;
    shift_len = pgsc_pkg::PULSE_BASE
              + pgsc_pkg::PULSE_STEP * pgsc_pkg::PulseW'(cur.gear);
    hold_sum  = {1'b0, cur.hold} + (pgsc_pkg::HoldW+1)'(interval);
    hold_sat  = hold_sum[pgsc_pkg::HoldW] ? '1 : hold_sum[pgsc_pkg::HoldW-1:0];
    started   = 1'b0;

    nxt = cur;
    res = '0;

    if (cur.kind != pgsc_pkg::KIND_NONE) begin
      if (cur.kind == pgsc_pkg::KIND_DOWN) begin
        res.down_solenoid = 1'b1;
      end else begin
        res.up_solenoid = 1'b1;
      end
      nxt.left = left_dec;
      if (left_dec == '0) begin
        unique case (cur.kind)
          pgsc_pkg::KIND_UP: begin
            if (cur.gear < TopGearL) nxt.gear = cur.gear + 3'd1;
            res.shift_event  = 1'b1;
            res.shift_was_up = 1'b1;
          end
          pgsc_pkg::KIND_DOWN: begin
            if (cur.gear > LowGear) nxt.gear = cur.gear - 3'd1;
            res.shift_event = 1'b1;
          end
          default: begin
          end
        endcase
        nxt.kind = pgsc_pkg::KIND_NONE;
      end
      nxt.div = '0;
    end else begin
      nxt.div = div_inc;
      if (div_inc >= interval) begin
        nxt.div = '0;
        if (up_button && !cur.lock && cur.gear < TopGearL) begin
          nxt.lock = 1'b1;
          nxt.kind = pgsc_pkg::KIND_UP;
          nxt.left = shift_len;
          started  = 1'b1;
        end else if (down_button && !cur.lock && cur.gear > LowGear) begin
          nxt.lock = 1'b1;
          nxt.kind = pgsc_pkg::KIND_DOWN;
          nxt.left = shift_len;
          started  = 1'b1;
        end
        if (!up_button && !down_button) nxt.lock = 1'b0;
        if (!started && cur.gear == LowGear && up_button && down_button) begin
          nxt.hold = hold_sat;
          if (hold_sat >= neutral_hold_ms) begin
            nxt.kind = pgsc_pkg::KIND_NEUTRAL;
            nxt.left = pgsc_pkg::NEUTRAL_PULSE;
            nxt.hold = '0;
          end
        end else begin
          nxt.hold = '0;
        end
      end
    end

    res.gear = nxt.gear;
  end

endmodule

// File: design/paddle_gear_shift_controller.sv
// paddle_gear_shift_controller: top level, state and config registers, output word register.
// Depends on pgsc_pkg and pgsc_step.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | in_tdata[7:0]  up_button, down_button
//   out_    | out | out_tvalid/tready  | out_tdata[7:0] solenoids, gear, event, dir
//   cfg_    | in  | cfg_we             | cfg_addr[1:0], cfg_wdata[15:0]
//
// One word per cycle while the output is not stalled; each input word yields its result
// word in the next cycle. The tick logic is a single combinational pass from the state
// registers to the output register. in_tready is high when the output register is empty or
// being drained, so a stalled output holds off input. Synchronous reset, active low:
// config registers return to defaults, gear loads the default start gear.
module paddle_gear_shift_controller #(
  parameter int unsigned TOP_GEAR = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] up_button, [1] down_button
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [0] up_solenoid, [1] down_solenoid,
                                                      // [4:2] gear, [5] shift_event,
                                                      // [6] shift_was_up
  input  logic                            cfg_we,
  input  logic [pgsc_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [pgsc_pkg::CfgDataW-1:0]   cfg_wdata
);

  localparam logic [pgsc_pkg::GearW-1:0] TopGearL = pgsc_pkg::GearW'(TOP_GEAR);

  logic [pgsc_pkg::HoldW-1:0] neutral_hold_r;
  logic [pgsc_pkg::DivW-1:0]  poll_interval_r;
  pgsc_pkg::ctl_state_t       st_r;
  pgsc_pkg::ctl_state_t       st_nxt;
  pgsc_pkg::ctl_state_t       step_st;
  pgsc_pkg::result_t          res_nxt;
  pgsc_pkg::result_t          res_r;
  logic                       out_valid_r;
  logic                       in_acc;
  logic [pgsc_pkg::GearW-1:0] cfg_gear;

  function automatic logic [pgsc_pkg::GearW-1:0] clamp_gear(
    input logic [pgsc_pkg::GearW-1:0] g
  );
    logic [pgsc_pkg::GearW-1:0] r;
    r = g;
    if (g == '0) r = 3'd1;
    else if (g > TopGearL) r = TopGearL;
    return r;
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_gear  = clamp_gear(cfg_wdata[pgsc_pkg::GearW-1:0]);

  pgsc_step #(
    .TOP_GEAR(TOP_GEAR)
  ) u_step (
    .cur             (st_r),
    .up_button       (in_tdata[0]),
    .down_button     (in_tdata[1]),
    .neutral_hold_ms (neutral_hold_r),
    .poll_interval   (poll_interval_r),
    .nxt             (step_st),
    .res             (res_nxt)
  );

  // start gear write overrides the tick's gear
  always_comb begin
    st_nxt = in_acc ? step_st : st_r;
    if (cfg_we && cfg_addr == pgsc_pkg::CFG_START_GEAR) st_nxt.gear = cfg_gear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_hold_r  <= pgsc_pkg::NEUTRAL_HOLD_RST;
      poll_interval_r <= pgsc_pkg::POLL_INTERVAL_RST;
      st_r.gear       <= pgsc_pkg::START_GEAR_RST;
      st_r.lock       <= 1'b0;
      st_r.hold       <= '0;
      st_r.left       <= '0;
      st_r.kind       <= pgsc_pkg::KIND_NONE;
      st_r.div        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          pgsc_pkg::CFG_NEUTRAL_HOLD:  neutral_hold_r  <= cfg_wdata;
          pgsc_pkg::CFG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[pgsc_pkg::DivW-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.shift_was_up, res_r.shift_event, res_r.gear,
                       res_r.down_solenoid, res_r.up_solenoid};

`ifndef SYNTHESIS
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gear != '0 && st_r.gear <= TopGearL)
    else $error("gear out of range");

  a_div_idle_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.kind != pgsc_pkg::KIND_NONE |-> st_r.div == '0)
    else $error("poll divider running during pulse");

  a_pulse_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.kind != pgsc_pkg::KIND_NONE |-> st_r.left != '0)
    else $error("active pulse with zero length");

  a_one_solenoid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.up_solenoid && res_r.down_solenoid))
    else $error("both solenoids driven");

  a_event_on_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.shift_event |-> res_r.up_solenoid || res_r.down_solenoid)
    else $error("shift event without solenoid drive");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for paddle_gear_shift_controller, one tick per input word.
// Predicts every result word from its own gear/lock/timer model; depends on pgsc_pkg.
module tb;

  localparam int TopGear = 6;
  localparam int PulseBase = 45;
  localparam int PulseStep = 5;
  localparam int NeutralTicks = 50;
  localparam int QuietLimit = 2000;
  localparam logic [pgsc_pkg::CfgAddrW-1:0] CfgUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [pgsc_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [pgsc_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // predictor state and registers
  logic [2:0] cur_gear;
  bit shift_lock;
  int unsigned hold_ms;
  logic [6:0] pulse_rem;
  pgsc_pkg::pulse_kind_t pulse_sel;
  logic [7:0] poll_cnt;
  logic [15:0] hold_limit;
  logic [7:0] poll_ival;

  pgsc_pkg::result_t pending_reports[$];
  pgsc_pkg::result_t seen_word, want_word;
  int fail_cnt = 0;
  int report_cnt = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int words_sent = 0;
  bit gaps_on = 1'b1;

  paddle_gear_shift_controller #(.TOP_GEAR(TopGear)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic pgsc_pkg::result_t advance_tick(input logic up, input logic dn);
    pgsc_pkg::result_t r;
    int unsigned ival;
    bit started;
    r = '0;
    if (pulse_sel != pgsc_pkg::KIND_NONE) begin
      if (pulse_sel == pgsc_pkg::KIND_DOWN) r.down_solenoid = 1'b1;
      else r.up_solenoid = 1'b1;
      if (pulse_rem > 0) pulse_rem = pulse_rem - 7'd1;
      if (pulse_rem == 0) begin
        if (pulse_sel == pgsc_pkg::KIND_UP) begin
          if (cur_gear < TopGear) cur_gear = cur_gear + 3'd1;
          r.shift_event = 1'b1;
          r.shift_was_up = 1'b1;
        end else if (pulse_sel == pgsc_pkg::KIND_DOWN) begin
          if (cur_gear > 1) cur_gear = cur_gear - 3'd1;
          r.shift_event = 1'b1;
        end
        pulse_sel = pgsc_pkg::KIND_NONE;
      end
      poll_cnt = '0;
    end else begin
      ival = (poll_ival == 0) ? 1 : poll_ival;
      poll_cnt = poll_cnt + 8'd1;
      if (poll_cnt >= ival) begin
        started = 1'b0;
        poll_cnt = '0;
        if (up && !shift_lock && cur_gear < TopGear) begin
          shift_lock = 1'b1;
          pulse_sel = pgsc_pkg::KIND_UP;
          pulse_rem = 7'(PulseBase + PulseStep * cur_gear);
          started = 1'b1;
        end else if (dn && !shift_lock && cur_gear > 1) begin
          shift_lock = 1'b1;
          pulse_sel = pgsc_pkg::KIND_DOWN;
          pulse_rem = 7'(PulseBase + PulseStep * cur_gear);
          started = 1'b1;
        end
        if (!up && !dn) shift_lock = 1'b0;
        if (!started && cur_gear == 1 && up && dn) begin
          hold_ms = hold_ms + ival;
          if (hold_ms > 65535) hold_ms = 65535;
          if (hold_ms >= hold_limit) begin
            pulse_sel = pgsc_pkg::KIND_NEUTRAL;
            pulse_rem = 7'(NeutralTicks);
            hold_ms = 0;
          end
        end else begin
          hold_ms = 0;
        end
      end
    end
    r.gear = cur_gear;
    return r;
  endfunction

  // one tick word; valid stays up when the next word follows at once
  task automatic send_tick(input logic up, input logic dn);
    if (gaps_on && $urandom_range(4, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, dn, up};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_reports.push_back(advance_tick(up, dn));
    words_sent++;
  endtask

  task automatic press(input logic up, input logic dn, input int n);
    repeat (n) send_tick(up, dn);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pgsc_pkg::CfgAddrW-1:0] idx,
                           input logic [pgsc_pkg::CfgDataW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pgsc_pkg::CFG_NEUTRAL_HOLD: hold_limit = val;
      pgsc_pkg::CFG_POLL_INTERVAL: poll_ival = val[7:0];
      pgsc_pkg::CFG_START_GEAR: begin
        cur_gear = (val[2:0] == 0) ? 3'd1 : (val[2:0] > TopGear) ? 3'(TopGear) : val[2:0];
      end
      default: ;
    endcase
  endtask

  task automatic test_registers();
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd0);
    press(1'b0, 1'b0, 3);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd7);
    press(1'b0, 1'b0, 3);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'hFFF3);
    press(1'b0, 1'b0, 3);
    write_reg(CfgUnused, 16'hFFFF);
    press(1'b0, 1'b0, 3);
    write_reg(pgsc_pkg::CFG_POLL_INTERVAL, 16'hFF00);  // zero interval acts as one
    press(1'b0, 1'b0, 3);
    write_reg(pgsc_pkg::CFG_NEUTRAL_HOLD, 16'hFFFF);
    write_reg(pgsc_pkg::CFG_NEUTRAL_HOLD, 16'd0);
    press(1'b0, 1'b0, 3);
  endtask

  // upshift into top gear, downshift out of it, no shift above top or below first gear
  task automatic test_shift_ladder();
    write_reg(pgsc_pkg::CFG_POLL_INTERVAL, 16'd1);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd5);
    press(1'b0, 1'b0, 2);
    press(1'b1, 1'b0, PulseBase + PulseStep * 5 + 3);
    press(1'b0, 1'b0, 2);
    press(1'b1, 1'b0, 5);
    press(1'b0, 1'b0, 2);
    press(1'b0, 1'b1, PulseBase + PulseStep * TopGear + 3);
    press(1'b0, 1'b0, 2);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd1);
    press(1'b0, 1'b1, 5);
    press(1'b0, 1'b0, 2);
  endtask

  task automatic test_lock_and_both();
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd3);
    press(1'b0, 1'b0, 2);
    press(1'b1, 1'b0, 80);
    press(1'b0, 1'b0, 2);
    press(1'b1, 1'b1, 70);
    press(1'b0, 1'b0, 2);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd1);
    press(1'b1, 1'b1, 20);
    press(1'b0, 1'b0, 2);
  endtask

  task automatic test_neutral();
    write_reg(pgsc_pkg::CFG_POLL_INTERVAL, 16'd3);
    write_reg(pgsc_pkg::CFG_NEUTRAL_HOLD, 16'd0);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd2);
    press(1'b0, 1'b0, 4);
    press(1'b0, 1'b1, 70);
    press(1'b1, 1'b1, 60);
    write_reg(pgsc_pkg::CFG_NEUTRAL_HOLD, 16'd20);
    press(1'b1, 1'b1, 12);
    press(1'b0, 1'b1, 6);
    press(1'b1, 1'b1, 80);
    press(1'b0, 1'b0, 5);
  endtask

  task automatic test_poll_max();
    write_reg(pgsc_pkg::CFG_POLL_INTERVAL, 16'd255);
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'd4);
    press(1'b1, 1'b0, 325);
    press(1'b0, 1'b0, 3);
  endtask

  task automatic run_random(input int n_words, input int hold_cap, input int poll_lo,
                            input int poll_hi);
    int start_cnt;
    int span;
    start_cnt = words_sent;
    write_reg(pgsc_pkg::CFG_NEUTRAL_HOLD, 16'($urandom_range(hold_cap, 0)));
    write_reg(pgsc_pkg::CFG_POLL_INTERVAL, 16'($urandom_range(poll_hi, poll_lo)));
    write_reg(pgsc_pkg::CFG_START_GEAR, 16'($urandom));
    span = 2 * poll_ival + 60;
    while (words_sent - start_cnt < n_words) begin
      case ($urandom_range(9, 0))
        0, 1, 2: begin
          press(1'b1, 1'b0, $urandom_range(span, 1));
          press(1'b0, 1'b0, $urandom_range(2 * poll_ival + 5, 1));
        end
        3, 4, 5: begin
          press(1'b0, 1'b1, $urandom_range(span, 1));
          press(1'b0, 1'b0, $urandom_range(2 * poll_ival + 5, 1));
        end
        6, 7: begin
          press(1'b0, 1'b1, $urandom_range(span, 1));
          press(1'b1, 1'b1, $urandom_range(hold_limit + span, 1));
          press(1'b0, 1'b0, $urandom_range(2 * poll_ival + 5, 1));
        end
        8: begin
          if ($urandom_range(1, 0)) drain();
          press(1'b1, 1'b1, $urandom_range(span, 1));
        end
        default: begin
          repeat ($urandom_range(20, 1))
            send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (gaps_on && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(8, 1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word.up_solenoid = out_tdata[0];
      seen_word.down_solenoid = out_tdata[1];
      seen_word.gear = out_tdata[4:2];
      seen_word.shift_event = out_tdata[5];
      seen_word.shift_was_up = out_tdata[6];
      if (pending_reports.size() == 0) begin
        fail_cnt++;
        if (report_cnt < 10)
          $display("tb: unexpected word %b at %0t", out_tdata, $realtime);
        report_cnt++;
      end else begin
        want_word = pending_reports.pop_front();
        if (seen_word !== want_word) begin
          fail_cnt++;
          if (report_cnt < 10)
            $display("tb: mismatch at %0t: exp sol_up=%b sol_dn=%b gear=%0d evt=%b up=%b,",
                     $realtime, want_word.up_solenoid, want_word.down_solenoid,
                     want_word.gear, want_word.shift_event, want_word.shift_was_up,
                     " got sol_up=%b sol_dn=%b gear=%0d evt=%b up=%b",
                     seen_word.up_solenoid, seen_word.down_solenoid, seen_word.gear,
                     seen_word.shift_event, seen_word.shift_was_up);
          report_cnt++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    cur_gear = 3'd1;
    shift_lock = 1'b0;
    hold_ms = 0;
    pulse_rem = '0;
    pulse_sel = pgsc_pkg::KIND_NONE;
    poll_cnt = '0;
    hold_limit = 16'd1000;
    poll_ival = 8'd10;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    press(1'b1, 1'b0, 80);  // defaults: slow poll, start in first gear
    press(1'b0, 1'b0, 12);
    test_registers();
    test_shift_ladder();
    test_lock_and_both();
    test_neutral();
    test_poll_max();
    run_random(40, 0, 1, 1);
    run_random(40, 40, 1, 8);
    run_random(40, 60, 9, 20);
    gaps_on = 1'b0;
    run_random(40, 30, 1, 5);
    drain();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: paddle_gear_shift_controller.f
design/pgsc_pkg.sv
design/pgsc_step.sv
design/paddle_gear_shift_controller.sv
verif/tb.sv
